/* rtl/seqno_time_sample_table_defines.svh */
// ----------------------------------------------------------------------------
// Seqno/time sample table assertion macros
// Shared property shapes for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SEQNO_TIME_SAMPLE_TABLE_DEFINES_SVH
`define SEQNO_TIME_SAMPLE_TABLE_DEFINES_SVH

// Same-cycle implication, held off during reset
`define STT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("seqno_time_sample_table: same-cycle check failed");

// Next-cycle implication, held off during reset
`define STT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("seqno_time_sample_table: next-cycle check failed");

`endif

/* rtl/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Item kinds, register indexes, datapath micro-ops and status for the
// seqno/time sample table.
// ----------------------------------------------------------------------------
package stt_pkg;

	// Item kinds
	typedef enum logic [1:0] {
		KIND_APPEND        = 2'd0,
		KIND_TIME_BEFORE   = 2'd1,
		KIND_SEQNO_BEFORE  = 2'd2,
		KIND_CUTOFF        = 2'd3
	} kind_t;

	// Configuration register indexes
	localparam logic [1:0] REG_CAPACITY  = 2'd0;
	localparam logic [1:0] REG_MAX_SPAN  = 2'd1;
	localparam logic [1:0] REG_PRESERVE  = 2'd2;
	localparam logic [1:0] REG_PRECLUDE  = 2'd3;

	localparam int SEQ_W  = 56;
	localparam int TIME_W = 64;
	localparam int PSEQ_W = 57;

	// Datapath micro-operations
	typedef enum logic [4:0] {
		OP_NONE     = 5'd0,
		OP_LOAD     = 5'd1,
		OP_REJECT   = 5'd2,
		OP_FIRST    = 5'd3,
		OP_READ     = 5'd4,
		OP_APPEND   = 5'd5,
		OP_SET_LAST = 5'd6,
		OP_CUT      = 5'd7,
		OP_IDX1     = 5'd8,
		OP_INC      = 5'd9,
		OP_SETK     = 5'd10,
		OP_SHRD     = 5'd11,
		OP_SHWR     = 5'd12,
		OP_SUB      = 5'd13,
		OP_IDX0     = 5'd14,
		OP_TA       = 5'd15,
		OP_TB       = 5'd16,
		OP_EV       = 5'd17,
		OP_DROP     = 5'd18,
		OP_Q_INIT   = 5'd19,
		OP_Q_TAKE   = 5'd20,
		OP_Q_END    = 5'd21,
		OP_T3A      = 5'd22,
		OP_T3B      = 5'd23,
		OP_OUT      = 5'd24
	} op_t;

	// Datapath status seen by the controller
	typedef struct packed {
		kind_t kind;
		logic  cap_zero;
		logic  seq_zero;
		logic  cnt_zero;
		logic  cnt_le1;
		logic  app_rej;
		logic  last_lt_span;
		logic  t_le_cut;
		logic  idx_end;
		logic  idx_one;
		logic  sh_last;
		logic  cp_go;
		logic  cp_more;
		logic  cp_last;
		logic  q_hit;
		logic  dur_zero;
		logic  prec_zero;
		logic  out_free;
	} stat_t;

endpackage

/* rtl/stt_ctrl.sv */
// ----------------------------------------------------------------------------
// stt_ctrl
// Sequencer for the sample table: issues one datapath micro-op per cycle
// and steps through append, age prune, count trim and lookup scans.
// ----------------------------------------------------------------------------
module stt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  stt_pkg::stat_t stat,
	output stt_pkg::op_t   op
);
	import stt_pkg::*;

	typedef enum logic [26:0] {
		S_IDLE     = 27'h0000001,
		S_DISP     = 27'h0000002,
		S_APP_RD   = 27'h0000004,
		S_APP_DEC  = 27'h0000008,
		S_AGE_ENT  = 27'h0000010,
		S_AGE_RDL  = 27'h0000020,
		S_AGE_CUT  = 27'h0000040,
		S_AGE_RD0  = 27'h0000080,
		S_AGE_CHK0 = 27'h0000100,
		S_AGE_LOOP = 27'h0000200,
		S_AGE_CHK  = 27'h0000400,
		S_SH_RD    = 27'h0000800,
		S_SH_WR    = 27'h0001000,
		S_SUB      = 27'h0002000,
		S_CP_ENT   = 27'h0004000,
		S_CP_RD0   = 27'h0008000,
		S_CP_A     = 27'h0010000,
		S_CP_RD1   = 27'h0020000,
		S_CP_B     = 27'h0040000,
		S_CP_RD    = 27'h0080000,
		S_CP_EV    = 27'h0100000,
		S_CP_DROP  = 27'h0200000,
		S_Q_LOOP   = 27'h0400000,
		S_Q_CHK    = 27'h0800000,
		S_Q_DONE   = 27'h1000000,
		S_FIN      = 27'h2000000,
		S_CP_LOOP  = 27'h4000000
	} state_t;

	state_t state_q, state_d;
	logic   trim_q, trim_d;     // shift sweep belongs to count trim
	logic   second_q, second_d; // second lookup of a cutoff item

	assign in_stall = (state_q != S_IDLE);

	// Next state and micro-op
	always_comb begin
		state_d  = state_q;
		trim_d   = trim_q;
		second_d = second_q;
		op       = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				second_d = 1'b0;
				if (stat.kind == KIND_APPEND) begin
					if (stat.cap_zero) begin
						op      = OP_REJECT;
						state_d = S_FIN;
					end else if (stat.seq_zero) begin
						state_d = S_AGE_ENT;
					end else if (stat.cnt_zero) begin
						op      = OP_FIRST;
						state_d = S_FIN;
					end else begin
						state_d = S_APP_RD;
					end
				end else if (stat.kind == KIND_CUTOFF && stat.dur_zero) begin
					state_d = S_FIN;
				end else begin
					op      = OP_Q_INIT;
					state_d = S_Q_LOOP;
				end
			end
			S_APP_RD: begin
				op      = OP_READ;
				state_d = S_APP_DEC;
			end
			S_APP_DEC: begin
				op      = OP_APPEND;
				state_d = stat.app_rej ? S_FIN : S_AGE_ENT;
			end
			// Age prune: read last time, derive cutoff, count leading drops
			S_AGE_ENT: begin
				if (stat.cnt_le1) begin
					state_d = S_CP_ENT;
				end else begin
					op      = OP_SET_LAST;
					state_d = S_AGE_RDL;
				end
			end
			S_AGE_RDL: begin
				op      = OP_READ;
				state_d = S_AGE_CUT;
			end
			S_AGE_CUT: begin
				if (stat.last_lt_span) begin
					state_d = S_CP_ENT;
				end else begin
					op      = OP_CUT;
					state_d = S_AGE_RD0;
				end
			end
			S_AGE_RD0: begin
				op      = OP_READ;
				state_d = S_AGE_CHK0;
			end
			S_AGE_CHK0: begin
				if (!stat.t_le_cut) begin
					state_d = S_CP_ENT;
				end else begin
					op      = OP_IDX1;
					state_d = S_AGE_LOOP;
				end
			end
			S_AGE_LOOP: begin
				if (stat.idx_end) begin
					op      = OP_SETK;
					trim_d  = 1'b0;
					state_d = S_SH_RD;
				end else begin
					op      = OP_READ;
					state_d = S_AGE_CHK;
				end
			end
			S_AGE_CHK: begin
				if (stat.t_le_cut) begin
					op      = OP_INC;
					state_d = S_AGE_LOOP;
				end else if (stat.idx_one) begin
					state_d = S_CP_ENT;
				end else begin
					op      = OP_SETK;
					trim_d  = 1'b0;
					state_d = S_SH_RD;
				end
			end
			// Shift sweep: move entries down by k, one read and one write per entry
			S_SH_RD: begin
				op      = OP_SHRD;
				state_d = S_SH_WR;
			end
			S_SH_WR: begin
				op      = OP_SHWR;
				state_d = stat.sh_last ? S_SUB : S_SH_RD;
			end
			S_SUB: begin
				op      = OP_SUB;
				state_d = trim_q ? S_CP_LOOP : S_CP_ENT;
			end
			// Count trim: find smallest gap, drop that inner entry, repeat
			S_CP_ENT: begin
				state_d = stat.cp_go ? S_CP_LOOP : S_FIN;
			end
			S_CP_LOOP: begin
				if (!stat.cp_more) begin
					state_d = S_FIN;
				end else begin
					op      = OP_IDX0;
					state_d = S_CP_RD0;
				end
			end
			S_CP_RD0: begin
				op      = OP_READ;
				state_d = S_CP_A;
			end
			S_CP_A: begin
				op      = OP_TA;
				state_d = S_CP_RD1;
			end
			S_CP_RD1: begin
				op      = OP_READ;
				state_d = S_CP_B;
			end
			S_CP_B: begin
				op      = OP_TB;
				state_d = S_CP_RD;
			end
			S_CP_RD: begin
				op      = OP_READ;
				state_d = S_CP_EV;
			end
			S_CP_EV: begin
				op      = OP_EV;
				state_d = stat.cp_last ? S_CP_DROP : S_CP_RD;
			end
			S_CP_DROP: begin
				op      = OP_DROP;
				trim_d  = 1'b1;
				state_d = S_SH_RD;
			end
			// Lookup scan over the rising prefix
			S_Q_LOOP: begin
				if (stat.idx_end) begin
					state_d = S_Q_DONE;
				end else begin
					op      = OP_READ;
					state_d = S_Q_CHK;
				end
			end
			S_Q_CHK: begin
				if (stat.q_hit) begin
					op      = OP_Q_TAKE;
					state_d = S_Q_LOOP;
				end else begin
					state_d = S_Q_DONE;
				end
			end
			S_Q_DONE: begin
				if (stat.kind != KIND_CUTOFF) begin
					op      = OP_Q_END;
					state_d = S_FIN;
				end else if (!second_q) begin
					op = OP_T3A;
					if (stat.prec_zero) begin
						state_d = S_FIN;
					end else begin
						second_d = 1'b1;
						state_d  = S_Q_LOOP;
					end
				end else begin
					op      = OP_T3B;
					state_d = S_FIN;
				end
			end
			// Hand the result to the output register once it is free
			S_FIN: begin
				if (stat.out_free) begin
					op      = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			trim_q   <= 1'b0;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			trim_q   <= trim_d;
			second_q <= second_d;
		end
	end

endmodule

/* rtl/stt_dpath.sv */
// ----------------------------------------------------------------------------
// stt_dpath
// Sample storage, configuration registers, scan registers and the output
// register; executes one micro-op per cycle from the controller.
// ----------------------------------------------------------------------------
module stt_dpath #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  stt_pkg::op_t                op,
	output stt_pkg::stat_t              stat,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_index,
	input  logic [63:0]                 cfg_data,
	input  logic [1:0]                  kind,
	input  logic [stt_pkg::SEQ_W-1:0]   seqno,
	input  logic [stt_pkg::TIME_W-1:0]  sample_time,
	input  logic [stt_pkg::TIME_W-1:0]  now_time,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        added,
	output logic                        rejected,
	output logic                        unknown,
	output logic [63:0]                 result_value,
	output logic                        cutoff_valid,
	output logic                        preclude_valid,
	output logic [stt_pkg::PSEQ_W-1:0]  preclude_seqno,
	output logic [7:0]                  entry_count
);
	import stt_pkg::*;

	localparam int STORE = TABLE_DEPTH + TABLE_DEPTH / 8 + 2;
	localparam int AW    = $clog2(STORE);
	localparam int CW    = $clog2(STORE + 1);

	// Sample storage
	logic [SEQ_W-1:0]  seq_mem  [STORE];
	logic [TIME_W-1:0] time_mem [STORE];

	// Configuration
	logic [7:0]        cap_q;
	logic [TIME_W-1:0] span_q, pres_q, prec_q;

	// Control counters
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q, k_q, best_q;

	// Item and scan registers
	kind_t             kind_q;
	logic [SEQ_W-1:0]  seq_q, rd_seq_q;
	logic [TIME_W-1:0] tm_q, now_q, key_q, cut_q, ta_q, tb_q, bg_q, rd_t_q;
	logic [63:0]       val_q;
	logic              first_q, found_q;

	// Result registers
	logic              r_added_q, r_rej_q, r_unk_q, r_cv_q, r_pv_q;
	logic [63:0]       r_val_q;
	logic [PSEQ_W-1:0] r_pseq_q;

	// Output register
	logic              out_valid_q;
	logic              o_added_q, o_rej_q, o_unk_q, o_cv_q, o_pv_q;
	logic [63:0]       o_val_q;
	logic [PSEQ_W-1:0] o_pseq_q;
	logic [CW+7:0]     o_cnt_q;

	logic [CW-1:0]     capc, capp, limit, cnt_m1, rsum;
	logic [TIME_W-1:0] dur, gap, wtime;
	logic [SEQ_W-1:0]  wseq;
	logic [CW-1:0]     waddr;
	logic              we, re, app_rej, app_add;

	// Effective capacity, clamped to the table, with one counted as two
	always_comb begin
		if (32'(cap_q) > 32'(TABLE_DEPTH)) begin
			capc = CW'(TABLE_DEPTH);
		end else begin
			capc = CW'(cap_q);
		end
		capp  = (capc == CW'(1)) ? CW'(2) : capc;
		limit = capp + (capp >> 3);
	end

	assign dur    = (pres_q > prec_q) ? pres_q : prec_q;
	assign cnt_m1 = cnt_q - CW'(1);
	assign gap    = rd_t_q - ta_q;
	assign rsum   = (op == OP_SHRD) ? (idx_q + k_q) : idx_q;
	assign re     = (op == OP_READ) || (op == OP_SHRD);

	// Append decision against the last entry
	assign app_rej = (rd_seq_q > seq_q);
	assign app_add = !app_rej && (rd_seq_q != seq_q) && (rd_t_q < tm_q) &&
		(cnt_q < CW'(STORE));

	// Write port select
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wseq  = rd_seq_q;
		wtime = rd_t_q;
		case (op)
			OP_FIRST: begin
				we    = 1'b1;
				waddr = '0;
				wseq  = seq_q;
				wtime = tm_q;
			end
			OP_APPEND: begin
				if (app_rej) begin
					we = 1'b0;
				end else if (rd_seq_q == seq_q) begin
					we    = 1'b1;
					wtime = (tm_q < rd_t_q) ? tm_q : rd_t_q;
				end else if (rd_t_q == tm_q) begin
					we   = 1'b1;
					wseq = seq_q;
				end else if (rd_t_q > tm_q) begin
					we    = 1'b1;
					wseq  = seq_q;
					wtime = tm_q;
				end else if (app_add) begin
					we    = 1'b1;
					waddr = cnt_q;
					wseq  = seq_q;
					wtime = tm_q;
				end
			end
			OP_SHWR: we = 1'b1;
			default: we = 1'b0;
		endcase
	end

	// Storage write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			seq_mem[waddr[AW-1:0]]  <= wseq;
			time_mem[waddr[AW-1:0]] <= wtime;
		end
		if (re) begin
			rd_seq_q <= seq_mem[rsum[AW-1:0]];
			rd_t_q   <= time_mem[rsum[AW-1:0]];
		end
	end

	// Configuration, count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= 8'd128;
			span_q      <= '1;
			pres_q      <= '0;
			prec_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_CAPACITY: cap_q  <= cfg_data[7:0];
					REG_MAX_SPAN: span_q <= cfg_data;
					REG_PRESERVE: pres_q <= cfg_data;
					REG_PRECLUDE: prec_q <= cfg_data;
					default:      cap_q  <= cap_q;
				endcase
			end
			case (op)
				OP_FIRST:  cnt_q <= CW'(1);
				OP_APPEND: if (app_add) cnt_q <= cnt_q + CW'(1);
				OP_SUB:    cnt_q <= cnt_q - k_q;
				default:   cnt_q <= cnt_q;
			endcase
			if (op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Scan, result and output payload registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				kind_q    <= kind_t'(kind);
				seq_q     <= seqno;
				tm_q      <= sample_time;
				now_q     <= now_time;
				idx_q     <= cnt_m1;
				r_added_q <= 1'b0;
				r_rej_q   <= 1'b0;
				r_unk_q   <= 1'b0;
				r_val_q   <= '0;
				r_cv_q    <= 1'b0;
				r_pv_q    <= 1'b0;
				r_pseq_q  <= '0;
			end
			OP_REJECT: r_rej_q <= 1'b1;
			OP_FIRST:  r_added_q <= 1'b1;
			OP_APPEND: begin
				r_rej_q   <= app_rej;
				r_added_q <= app_add;
			end
			OP_SET_LAST: idx_q <= cnt_m1;
			OP_CUT: begin
				cut_q <= rd_t_q - span_q;
				idx_q <= '0;
			end
			OP_IDX1: idx_q <= CW'(1);
			OP_INC:  idx_q <= idx_q + CW'(1);
			OP_SETK: begin
				k_q   <= idx_q - CW'(1);
				idx_q <= '0;
			end
			OP_SHWR: idx_q <= idx_q + CW'(1);
			OP_IDX0: idx_q <= '0;
			OP_TA: begin
				ta_q  <= rd_t_q;
				idx_q <= CW'(1);
			end
			OP_TB: begin
				tb_q    <= rd_t_q;
				idx_q   <= CW'(2);
				first_q <= 1'b1;
			end
			OP_EV: begin
				// keep the oldest entry on a tie
				if (first_q || (gap < bg_q)) begin
					bg_q   <= gap;
					best_q <= idx_q - CW'(1);
				end
				ta_q    <= tb_q;
				tb_q    <= rd_t_q;
				first_q <= 1'b0;
				idx_q   <= idx_q + CW'(1);
			end
			OP_DROP: begin
				idx_q <= best_q;
				k_q   <= CW'(1);
			end
			OP_Q_INIT: begin
				idx_q   <= '0;
				val_q   <= '0;
				found_q <= 1'b0;
				if (kind_q == KIND_SEQNO_BEFORE) begin
					key_q <= tm_q;
				end else begin
					key_q <= (now_q > dur) ? (now_q - dur) : '0;
				end
			end
			OP_Q_TAKE: begin
				val_q   <= (kind_q == KIND_TIME_BEFORE) ? rd_t_q : 64'(rd_seq_q);
				found_q <= 1'b1;
				idx_q   <= idx_q + CW'(1);
			end
			OP_Q_END: begin
				r_val_q <= val_q;
				r_unk_q <= !found_q;
			end
			OP_T3A: begin
				r_val_q <= val_q + 64'd1;
				r_cv_q  <= 1'b1;
				idx_q   <= '0;
				val_q   <= '0;
				key_q   <= (now_q > prec_q) ? (now_q - prec_q) : '0;
			end
			OP_T3B: begin
				r_pv_q   <= 1'b1;
				r_pseq_q <= val_q[PSEQ_W-1:0] + PSEQ_W'(1);
			end
			OP_OUT: begin
				o_added_q <= r_added_q;
				o_rej_q   <= r_rej_q;
				o_unk_q   <= r_unk_q;
				o_val_q   <= r_val_q;
				o_cv_q    <= r_cv_q;
				o_pv_q    <= r_pv_q;
				o_pseq_q  <= r_pseq_q;
				o_cnt_q   <= (CW + 8)'(cnt_q);
			end
			default: idx_q <= idx_q;
		endcase
	end

	// Status to the controller
	always_comb begin
		stat.kind         = kind_q;
		stat.cap_zero     = (capc == '0);
		stat.seq_zero     = (seq_q == '0);
		stat.cnt_zero     = (cnt_q == '0);
		stat.cnt_le1      = (cnt_q <= CW'(1));
		stat.app_rej      = app_rej;
		stat.last_lt_span = (rd_t_q < span_q);
		stat.t_le_cut     = (rd_t_q <= cut_q);
		stat.idx_end      = (idx_q >= cnt_q);
		stat.idx_one      = (idx_q == CW'(1));
		stat.sh_last      = ((idx_q + CW'(1)) == (cnt_q - k_q));
		stat.cp_go        = (cnt_q > limit) && (cnt_q >= CW'(3));
		stat.cp_more      = (cnt_q > capp) && (cnt_q >= CW'(3));
		stat.cp_last      = ((idx_q + CW'(1)) == cnt_q);
		stat.q_hit        = (kind_q == KIND_TIME_BEFORE) ? (rd_seq_q < seq_q)
			: (rd_t_q <= key_q);
		stat.dur_zero     = (dur == '0);
		stat.prec_zero    = (prec_q == '0);
		stat.out_free     = !out_valid_q || !out_stall;
	end

	assign out_valid      = out_valid_q;
	assign added          = o_added_q;
	assign rejected       = o_rej_q;
	assign unknown        = o_unk_q;
	assign result_value   = o_val_q;
	assign cutoff_valid   = o_cv_q;
	assign preclude_valid = o_pv_q;
	assign preclude_seqno = o_pseq_q;
	assign entry_count    = o_cnt_q[7:0];

endmodule

/* rtl/seqno_time_sample_table.sv */
// ----------------------------------------------------------------------------
// seqno_time_sample_table
// Sorted table of (seqno, time) samples with append, pruning and lookups.
// ----------------------------------------------------------------------------
// Usage: one item enters on in_valid/in_stall (kind, seqno, sample_time,
// now_time); exactly one result leaves on out_valid/out_stall. The block
// works on one item at a time: in_stall is high from acceptance until the
// result is loaded into the output register, so the next item can enter
// while that result still waits for the receiver.
// The sample memory takes one access per cycle, so the time an item takes
// grows with the entries it touches: a lookup scans the rising prefix (again
// for a cutoff with a preclude window); an append reads the last entry, then
// the age prune checks and moves entries, and each count-trim removal scans
// the gaps over all entries held and moves the entries above the dropped one.
// A receiver stall holds the result; an item that finishes meanwhile waits.
// Reset empties the table and loads capacity 128, max span all ones, and
// zero tiering windows; no clearing pass runs. Registers are written through
// cfg_wr_en/cfg_index/cfg_data and are used by every step that follows.
// ----------------------------------------------------------------------------
`include "seqno_time_sample_table_defines.svh"

module seqno_time_sample_table #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_index,
	input  logic [63:0]                 cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  kind,
	input  logic [stt_pkg::SEQ_W-1:0]   seqno,
	input  logic [stt_pkg::TIME_W-1:0]  sample_time,
	input  logic [stt_pkg::TIME_W-1:0]  now_time,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        added,
	output logic                        rejected,
	output logic                        unknown,
	output logic [63:0]                 result_value,
	output logic                        cutoff_valid,
	output logic                        preclude_valid,
	output logic [stt_pkg::PSEQ_W-1:0]  preclude_seqno,
	output logic [7:0]                  entry_count
);
	import stt_pkg::*;

	op_t   op;
	stat_t stat;

	stt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.op       (op)
	);

	stt_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.stat           (stat),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.kind           (kind),
		.seqno          (seqno),
		.sample_time    (sample_time),
		.now_time       (now_time),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.added          (added),
		.rejected       (rejected),
		.unknown        (unknown),
		.result_value   (result_value),
		.cutoff_valid   (cutoff_valid),
		.preclude_valid (preclude_valid),
		.preclude_seqno (preclude_seqno),
		.entry_count    (entry_count)
	);

	// An accepted item keeps the input side busy on the next cycle
	`STT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	// A result is loaded only while the controller is finishing an item
	`STT_ASSERT_NEXT(a_out_from_fin, op == OP_OUT, out_valid && !in_stall)
	// An append never both adds and is refused
	`STT_ASSERT_NOW(a_added_xor_rej, out_valid, !(added && rejected))
	// The preclude cutoff only comes with the preserve cutoff
	`STT_ASSERT_NOW(a_preclude_in_cutoff, out_valid && preclude_valid, cutoff_valid)

endmodule

/* verif/sample_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample table checker
// Watches the register port and both item channels of the seqno/time sample
// table, keeps its own copy of the table and registers, predicts the result
// of every accepted item and compares each returned result field by field.
// ----------------------------------------------------------------------------
module sample_table_checker #(
	parameter int DEPTH = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_index,
	input  logic [63:0]                 cfg_data,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [1:0]                  kind,
	input  logic [stt_pkg::SEQ_W-1:0]   seqno,
	input  logic [stt_pkg::TIME_W-1:0]  sample_time,
	input  logic [stt_pkg::TIME_W-1:0]  now_time,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic                        added,
	input  logic                        rejected,
	input  logic                        unknown,
	input  logic [63:0]                 result_value,
	input  logic                        cutoff_valid,
	input  logic                        preclude_valid,
	input  logic [stt_pkg::PSEQ_W-1:0]  preclude_seqno,
	input  logic [7:0]                  entry_count,
	output int                          errors,
	output int                          pending
);
	import stt_pkg::*;

	localparam int STORE = DEPTH + DEPTH / 8 + 2;

	typedef struct {
		logic              added;
		logic              rejected;
		logic              unknown;
		logic [63:0]       value;
		logic              cvalid;
		logic              pvalid;
		logic [PSEQ_W-1:0] pseq;
		logic [7:0]        count;
	} table_result_t;

	logic [SEQ_W-1:0]  tbl_seq [0:STORE-1];
	logic [TIME_W-1:0] tbl_time [0:STORE-1];
	int                held;
	logic [7:0]        capacity;
	logic [63:0]       max_span;
	logic [63:0]       preserve_win;
	logic [63:0]       preclude_win;
	table_result_t     expected_results [$];

	// Remove entry i, closing the gap
	function automatic void drop_entry(int i);
		for (int j = i; j < held - 1; j++) begin
			tbl_seq[j]  = tbl_seq[j + 1];
			tbl_time[j] = tbl_time[j + 1];
		end
		held--;
	endfunction

	function automatic void prune_by_age();
		logic [63:0] cut;
		if (held <= 1) return;
		if (tbl_time[held - 1] < max_span) return;
		cut = tbl_time[held - 1] - max_span;
		while (held >= 2 && tbl_time[0] <= cut && tbl_time[1] <= cut)
			drop_entry(0);
	endfunction

	// Greedy trim: drop the inner entry leaving the smallest gap, oldest on a tie
	function automatic void prune_by_count(int cap);
		int best;
		logic [63:0] best_gap, gap;
		if (held <= cap + cap / 8 || held < 3) return;
		while (held > cap && held >= 3) begin
			best = 1;
			best_gap = tbl_time[2] - tbl_time[0];
			for (int i = 2; i + 1 < held; i++) begin
				gap = tbl_time[i + 1] - tbl_time[i - 1];
				if (gap < best_gap) begin
					best_gap = gap;
					best = i;
				end
			end
			drop_entry(best);
		end
	endfunction

	// Seqno of the last entry in the rising prefix with time <= t
	function automatic logic seqno_at_time(logic [63:0] t, output logic [SEQ_W-1:0] v);
		int i;
		i = 0;
		while (i < held && tbl_time[i] <= t) i++;
		v = (i == 0) ? '0 : tbl_seq[i - 1];
		return i != 0;
	endfunction

	function automatic logic time_before_seq(logic [SEQ_W-1:0] s, output logic [63:0] v);
		int i;
		i = 0;
		while (i < held && tbl_seq[i] < s) i++;
		v = (i == 0) ? '0 : tbl_time[i - 1];
		return i != 0;
	endfunction

	function automatic table_result_t apply_item(kind_t k, logic [SEQ_W-1:0] s,
			logic [63:0] t, logic [63:0] now);
		table_result_t r;
		int cap, l;
		logic do_prune, hit;
		logic [SEQ_W-1:0] sv;
		logic [63:0] tv, dur, pt;
		r = '{default: '0};
		case (k)
			KIND_APPEND: begin
				cap = (capacity > DEPTH) ? DEPTH : int'(capacity);
				do_prune = 1'b1;
				if (cap == 0) begin
					r.rejected = 1'b1;
					do_prune = 1'b0;
				end else if (s == 0) begin
					// skip, but still prune
				end else if (held == 0) begin
					tbl_seq[0] = s;
					tbl_time[0] = t;
					held = 1;
					r.added = 1'b1;
					do_prune = 1'b0;
				end else begin
					l = held - 1;
					if (tbl_seq[l] > s) begin
						r.rejected = 1'b1;
						do_prune = 1'b0;
					end else if (tbl_seq[l] == s) begin
						if (t < tbl_time[l]) tbl_time[l] = t;
					end else if (tbl_time[l] == t) begin
						tbl_seq[l] = s;
					end else if (tbl_time[l] > t) begin
						tbl_seq[l] = s;
						tbl_time[l] = t;
					end else if (held < STORE) begin
						tbl_seq[held] = s;
						tbl_time[held] = t;
						held++;
						r.added = 1'b1;
					end
				end
				if (do_prune) begin
					if (cap == 1) cap = 2;
					prune_by_age();
					prune_by_count(cap);
				end
			end
			KIND_TIME_BEFORE: begin
				hit = time_before_seq(s, tv);
				r.unknown = !hit;
				r.value = tv;
			end
			KIND_SEQNO_BEFORE: begin
				hit = seqno_at_time(t, sv);
				r.unknown = !hit;
				r.value = 64'(sv);
			end
			default: begin
				dur = (preserve_win > preclude_win) ? preserve_win : preclude_win;
				if (dur != 0) begin
					r.cvalid = 1'b1;
					pt = (now > dur) ? now - dur : '0;
					hit = seqno_at_time(pt, sv);
					r.value = 64'(sv) + 64'd1;
					if (preclude_win != 0) begin
						r.pvalid = 1'b1;
						pt = (now > preclude_win) ? now - preclude_win : '0;
						hit = seqno_at_time(pt, sv);
						r.pseq = PSEQ_W'(sv) + 1'b1;
					end
				end
			end
		endcase
		r.count = 8'(held);
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
		if (exp !== act) begin
			$display("%0t: %s expected %0h got %0h", $time, name, exp, act);
			errors++;
		end
	endfunction

	// Track registers, predict accepted items, compare returned results
	always @(posedge clk or negedge arst_n) begin
		table_result_t e;
		if (!arst_n) begin
			held = 0;
			capacity = 8'd128;
			max_span = '1;
			preserve_win = '0;
			preclude_win = '0;
			expected_results.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_CAPACITY: capacity = cfg_data[7:0];
					REG_MAX_SPAN: max_span = cfg_data;
					REG_PRESERVE: preserve_win = cfg_data;
					REG_PRECLUDE: preclude_win = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected (value %0h)", $time,
						result_value);
					errors++;
				end else begin
					e = expected_results[0];
					expected_results.delete(0);
					check_field("added", e.added, added);
					check_field("rejected", e.rejected, rejected);
					check_field("unknown", e.unknown, unknown);
					check_field("result_value", e.value, result_value);
					check_field("cutoff_valid", e.cvalid, cutoff_valid);
					check_field("preclude_valid", e.pvalid, preclude_valid);
					check_field("preclude_seqno", e.pseq, preclude_seqno);
					check_field("entry_count", e.count, entry_count);
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(apply_item(kind_t'(kind), seqno, sample_time,
					now_time));
			pending = expected_results.size();
		end
	end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample table testbench
// Drives directed and random append and lookup items through the sample
// table under several register settings with random idling on both sides,
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
	import stt_pkg::*;

	localparam longint unsigned CYCLE_LIMIT = 20000000;
	localparam logic [63:0] ALL_ONES = '1;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [1:0]          cfg_index;
	logic [63:0]         cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          kind;
	logic [SEQ_W-1:0]    seqno;
	logic [TIME_W-1:0]   sample_time;
	logic [TIME_W-1:0]   now_time;
	logic                out_valid;
	logic                out_stall;
	logic                added;
	logic                rejected;
	logic                unknown;
	logic [63:0]         result_value;
	logic                cutoff_valid;
	logic                preclude_valid;
	logic [PSEQ_W-1:0]   preclude_seqno;
	logic [7:0]          entry_count;
	int                  errors;
	int                  pending;

	logic                calm;
	logic                hold_req;
	longint unsigned     cycles;
	logic [SEQ_W-1:0]    next_seq;
	logic [63:0]         next_time;

	seqno_time_sample_table dut (.*);

	sample_table_checker chk (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Abort on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold-off, calm stretch
	initial begin
		logic held_done;
		held_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held_done) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				held_done = 1'b1;
				out_stall <= 1'b0;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 14);
			end
		end
	end

	task automatic send_item(kind_t k, logic [SEQ_W-1:0] s, logic [63:0] t,
			logic [63:0] now);
		while (!calm && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		seqno <= s;
		sample_time <= t;
		now_time <= now;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
	endtask

	// Hold the sender until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(logic [63:0] cap, logic [63:0] span, logic [63:0] pres,
			logic [63:0] prec);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_CAPACITY;
		cfg_data <= cap;
		@(posedge clk);
		cfg_index <= REG_MAX_SPAN;
		cfg_data <= span;
		@(posedge clk);
		cfg_index <= REG_PRESERVE;
		cfg_data <= pres;
		@(posedge clk);
		cfg_index <= REG_PRECLUDE;
		cfg_data <= prec;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Mostly well-formed appends, with skips, reorders and lookups mixed in
	task automatic random_items(int n);
		int r;
		logic [SEQ_W-1:0] s;
		logic [63:0] t;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				next_seq = next_seq + SEQ_W'($urandom_range(0, 3));
				if ($urandom_range(0, 9) == 0)
					next_time = next_time - 64'($urandom_range(0, 4));
				else
					next_time = next_time + 64'($urandom_range(0, 6));
				send_item(KIND_APPEND, next_seq, next_time, rand64());
			end else if (r < 74) begin
				send_item(KIND_APPEND, '0, rand64(), rand64());
			end else if (r < 78) begin
				s = next_seq - SEQ_W'($urandom_range(1, 20));
				send_item(KIND_APPEND, s, next_time + 64'($urandom_range(0, 3)), rand64());
			end else if (r < 85) begin
				send_item(kind_t'($urandom_range(1, 3)), SEQ_W'(rand64()), rand64(),
					rand64());
			end else begin
				s = next_seq - SEQ_W'($urandom_range(0, 300));
				t = next_time - 64'($urandom_range(0, 600));
				send_item(kind_t'($urandom_range(1, 3)), s, t,
					t + 64'($urandom_range(0, 300)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cycles = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_CAPACITY;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_APPEND;
		seqno = '0;
		sample_time = '0;
		now_time = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, merge rules, rejection, lookups
		send_item(KIND_TIME_BEFORE, '0, '0, '0);
		send_item(KIND_SEQNO_BEFORE, '0, ALL_ONES, '0);
		send_item(KIND_CUTOFF, '0, '0, ALL_ONES);
		send_item(KIND_APPEND, '0, 64'd5, '0);
		send_item(KIND_APPEND, 56'd10, 64'd100, '0);
		send_item(KIND_APPEND, 56'd10, 64'd90, '0);
		send_item(KIND_APPEND, 56'd10, 64'd95, '0);
		send_item(KIND_APPEND, 56'd12, 64'd90, '0);
		send_item(KIND_APPEND, 56'd13, 64'd80, '0);
		send_item(KIND_APPEND, 56'd5, 64'd200, '0);
		send_item(KIND_APPEND, 56'd20, 64'd300, '0);
		send_item(KIND_TIME_BEFORE, '0, '0, '0);
		send_item(KIND_TIME_BEFORE, 56'd13, '0, '0);
		send_item(KIND_TIME_BEFORE, '1, '0, '0);
		send_item(KIND_SEQNO_BEFORE, '0, 64'd0, '0);
		send_item(KIND_SEQNO_BEFORE, '0, 64'd85, '0);
		drain();
		write_regs(64'd0, ALL_ONES, 64'd50, 64'd20);
		send_item(KIND_APPEND, 56'd30, 64'd400, '0);
		send_item(KIND_CUTOFF, '0, '0, 64'd0);
		send_item(KIND_CUTOFF, '0, '0, 64'd350);
		send_item(KIND_CUTOFF, '0, '0, ALL_ONES);
		drain();
		write_regs(64'd2, ALL_ONES, 64'd0, 64'd40);
		send_item(KIND_CUTOFF, '0, '0, 64'd330);
		send_item(KIND_APPEND, 56'd40, 64'd500, '0);
		drain();

		next_seq = 56'd50;
		next_time = 64'd1000;

		// Random phases under varied register settings
		write_regs(64'd3, ALL_ONES, 64'd30, 64'd10);
		random_items(200);
		drain();
		write_regs(64'd1, 64'd40, ALL_ONES, 64'd0);
		random_items(200);
		drain();
		write_regs(64'd8, 64'd0, 64'd0, ALL_ONES);
		hold_req <= 1'b1;
		random_items(200);
		drain();
		write_regs(64'hFFFF_FF80, ALL_ONES, 64'd100, 64'd200);
		calm <= 1'b1;
		random_items(250);
		drain();
		calm <= 1'b0;
		write_regs(64'd20, 64'd60, 64'd5, 64'd5);
		random_items(250);
		drain();
		write_regs(64'd255, 64'd300, rand64(), rand64());
		random_items(200);
		drain();
		write_regs(64'd0, rand64(), 64'd0, 64'd0);
		random_items(40);
		drain();

		// Top of the ranges: seqno and time near all ones
		write_regs(64'd5, 64'd25, 64'd70, 64'd30);
		next_seq = '1 - SEQ_W'(400);
		next_time = ALL_ONES - 64'd2000;
		random_items(350);
		send_item(KIND_APPEND, '1, ALL_ONES, ALL_ONES);
		send_item(KIND_TIME_BEFORE, '1, ALL_ONES, ALL_ONES);
		send_item(KIND_SEQNO_BEFORE, '1, ALL_ONES, ALL_ONES);
		send_item(KIND_CUTOFF, '1, ALL_ONES, ALL_ONES);
		drain();
		repeat (20) @(posedge clk);

		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/stt_pkg.sv
rtl/stt_ctrl.sv
rtl/stt_dpath.sv
rtl/seqno_time_sample_table.sv
verif/sample_table_checker.sv
verif/testbench.sv
